/* sv/dls_pkg.sv */
package dls_pkg;

	localparam int MAX_BREAK_BYTES = 8;
	localparam int WIN_DEPTH = (MAX_BREAK_BYTES < 8) ? MAX_BREAK_BYTES : 8;
	localparam int FILL_W = $clog2(WIN_DEPTH + 1);
	localparam int IDX_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int SEG_W = 17;
	localparam logic [SEG_W-1:0] SEG_MAX = {SEG_W{1'b1}};

	localparam logic [1:0] CFG_BREAK_BYTES = 2'd0;
	localparam logic [1:0] CFG_BREAK_LENGTH = 2'd1;
	localparam logic [1:0] CFG_LINE_INDEX = 2'd2;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_present;
		logic       end_of_text;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       byte_valid;
		logic       line_done;
	} out_beat_t;

	typedef struct packed {
		logic [63:0]       break_bytes;
		logic [FILL_W-1:0] break_length;
		logic [15:0]       line_index;
	} cfg_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_present;
		logic       end_of_text;
		logic       zero_end;
	} job_t;

endpackage

/* sv/dls_front.sv */
module dls_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dls_pkg::in_beat_t in_data,
	input  dls_pkg::cfg_t    cfg,
	output logic             job_valid,
	input  logic             job_pop,
	output dls_pkg::job_t    job
);

	dls_pkg::job_t queue_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          accept;
	logic          push;
	logic          zero_len;
	dls_pkg::job_t new_job;

	// With no break string in use, only the end of a text has any effect.
	assign zero_len = (cfg.break_length == '0);
	assign in_ready = (count_q != 2'd2);
	assign accept = in_valid && in_ready;
	assign push = accept && !(zero_len && !in_data.end_of_text);
	assign job_valid = (count_q != 2'd0);
	assign job = queue_q[rd_ptr_q];

	always_comb begin
		new_job.text_byte = in_data.text_byte;
		new_job.byte_present = in_data.byte_present;
		new_job.end_of_text = in_data.end_of_text;
		new_job.zero_end = zero_len;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (job_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !job_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && job_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* sv/dls_back.sv */
module dls_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dls_pkg::cfg_t      cfg,
	input  logic               job_valid,
	output logic               job_pop,
	input  dls_pkg::job_t      job,
	output logic               out_valid,
	input  logic               out_ready,
	output dls_pkg::out_beat_t out_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t                      state_q;
	logic [7:0]                  win_q [dls_pkg::WIN_DEPTH];
	logic [dls_pkg::FILL_W-1:0]  fill_q;
	logic [dls_pkg::SEG_W-1:0]   seg_q;
	logic                        end_q;
	logic                        out_valid_q;
	dls_pkg::out_beat_t          out_data_q;
	logic                        ostall;
	logic                        is_prefix;
	logic                        selected;

	assign ostall = out_valid_q && !out_ready;
	assign job_pop = (state_q == ST_IDLE) && job_valid && !ostall;
	assign selected = (seg_q == {1'b0, cfg.line_index});
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		is_prefix = (fill_q <= cfg.break_length);
		for (int k = 0; k < dls_pkg::WIN_DEPTH; k++) begin
			if ((dls_pkg::FILL_W'(k) < fill_q) && (win_q[k] != cfg.break_bytes[8*k +: 8])) begin
				is_prefix = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			seg_q <= '0;
			end_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!ostall) begin
				unique case (state_q)
					ST_IDLE: begin
						if (job_valid && job.zero_end) begin
							fill_q <= '0;
							seg_q <= '0;
							out_valid_q <= 1'b1;
							out_data_q <= '{line_byte: 8'd0, byte_valid: 1'b0, line_done: 1'b1};
						end else begin
							out_valid_q <= 1'b0;
							if (job_valid) begin
								if (job.byte_present &&
										(fill_q < dls_pkg::FILL_W'(dls_pkg::WIN_DEPTH))) begin
									win_q[fill_q[dls_pkg::IDX_W-1:0]] <= job.text_byte;
									fill_q <= fill_q + 1'b1;
								end
								end_q <= job.end_of_text;
								state_q <= ST_SCAN;
							end
						end
					end
					ST_SCAN: begin
						if ((fill_q != '0) && !is_prefix) begin
							for (int k = 0; k < dls_pkg::WIN_DEPTH - 1; k++) begin
								win_q[k] <= win_q[k+1];
							end
							fill_q <= fill_q - 1'b1;
							out_valid_q <= selected;
							if (selected) begin
								out_data_q <= '{line_byte: win_q[0], byte_valid: 1'b1, line_done: 1'b0};
							end
						end else begin
							out_valid_q <= 1'b0;
							if (fill_q == cfg.break_length) begin
								fill_q <= '0;
								if (seg_q != dls_pkg::SEG_MAX) begin
									seg_q <= seg_q + 1'b1;
								end
							end
							state_q <= end_q ? ST_FLUSH : ST_IDLE;
						end
					end
					ST_FLUSH: begin
						if (fill_q != '0) begin
							for (int k = 0; k < dls_pkg::WIN_DEPTH - 1; k++) begin
								win_q[k] <= win_q[k+1];
							end
							fill_q <= fill_q - 1'b1;
							out_valid_q <= selected;
							if (selected) begin
								out_data_q <= '{line_byte: win_q[0], byte_valid: 1'b1, line_done: 1'b0};
							end
						end else begin
							seg_q <= '0;
							out_valid_q <= 1'b1;
							out_data_q <= '{line_byte: 8'd0, byte_valid: 1'b0, line_done: 1'b1};
							state_q <= ST_IDLE;
						end
					end
					default: begin
						out_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule

/* sv/delimited_line_selector.sv */
// A byte that is resolved at once passes through the queue, the window and the output register.
// Each text beat is popped from the queue in the idle state and then scanned; the scan sheds
// one byte a cycle from the window while the output is not stalled, and the flush ends a text.
// A two-entry queue decouples input from the scan, so beats are still taken while a result waits
// until the queue is full. Reset empties the queue and clears the window fill and segment counter.
module delimited_line_selector (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dls_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output dls_pkg::out_beat_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	logic [63:0]   break_bytes_q;
	logic [3:0]    break_length_q;
	logic [15:0]   line_index_q;
	dls_pkg::cfg_t cfg;
	logic          job_valid;
	logic          job_pop;
	dls_pkg::job_t job;

	assign cfg_ready = 1'b1;

	always_comb begin
		cfg.break_bytes = break_bytes_q;
		cfg.line_index = line_index_q;
		if (break_length_q > 4'(dls_pkg::WIN_DEPTH)) begin
			cfg.break_length = dls_pkg::FILL_W'(dls_pkg::WIN_DEPTH);
		end else begin
			cfg.break_length = dls_pkg::FILL_W'(break_length_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_bytes_q <= 64'd0;
			break_length_q <= 4'd1;
			line_index_q <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dls_pkg::CFG_BREAK_BYTES:  break_bytes_q <= cfg_data;
				dls_pkg::CFG_BREAK_LENGTH: break_length_q <= cfg_data[3:0];
				dls_pkg::CFG_LINE_INDEX:   line_index_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	dls_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg       (cfg),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (job)
	);

	dls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* tb/sv/delimited_line_selector_test.sv */
class segment_tracker;
	logic [63:0]        brk_str;
	logic [3:0]         brk_len;
	logic [15:0]        sel_line;
	logic [7:0]         window [dls_pkg::MAX_BREAK_BYTES];
	int unsigned        fill;
	logic [16:0]        seg;
	dls_pkg::out_beat_t awaited[$];
	int unsigned        faults;

	function new();
		faults = 0;
		brk_str = '0;
		brk_len = 4'd1;
		sel_line = '0;
		fill = 0;
		seg = '0;
		foreach (window[k]) window[k] = 8'h00;
	endfunction

	function void write_reg(logic [1:0] idx, logic [63:0] val);
		case (idx)
			dls_pkg::CFG_BREAK_BYTES: brk_str = val;
			dls_pkg::CFG_BREAK_LENGTH: brk_len = val[3:0];
			dls_pkg::CFG_LINE_INDEX: sel_line = val[15:0];
			default: ;
		endcase
	endfunction

	function bit window_is_prefix(int unsigned len);
		if (fill > len) return 1'b0;
		for (int k = 0; k < fill; k++) begin
			if (window[k] != brk_str[8*k +: 8]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function void emit(logic [7:0] b, logic v, logic d);
		dls_pkg::out_beat_t r;
		r = '{line_byte: b, byte_valid: v, line_done: d};
		awaited.push_back(r);
	endfunction

	function void shed_head();
		logic [7:0] b;
		b = window[0];
		for (int k = 1; k < fill; k++) window[k-1] = window[k];
		fill--;
		if (seg == {1'b0, sel_line}) emit(b, 1'b1, 1'b0);
	endfunction

	function void absorb_beat(dls_pkg::in_beat_t beat);
		int unsigned len;
		len = brk_len;
		if (len > dls_pkg::MAX_BREAK_BYTES) len = dls_pkg::MAX_BREAK_BYTES;
		if (len > 8) len = 8;
		if (len == 0) begin
			if (beat.end_of_text) begin
				fill = 0;
				seg = '0;
				emit(8'h00, 1'b0, 1'b1);
			end
			return;
		end
		if (beat.byte_present && fill < dls_pkg::MAX_BREAK_BYTES) begin
			window[fill] = beat.text_byte;
			fill++;
		end
		while (fill > 0 && !window_is_prefix(len)) shed_head();
		if (fill == len) begin
			fill = 0;
			if (seg < dls_pkg::SEG_MAX) seg++;
		end
		if (beat.end_of_text) begin
			while (fill > 0) shed_head();
			seg = '0;
			emit(8'h00, 1'b0, 1'b1);
		end
	endfunction

	function void compare_result(dls_pkg::out_beat_t got);
		dls_pkg::out_beat_t want;
		if (awaited.size() == 0) begin
			$error("unexpected result beat: line_byte %h byte_valid %b line_done %b",
				got.line_byte, got.byte_valid, got.line_done);
			faults++;
			return;
		end
		want = awaited.pop_front();
		if (got.line_byte !== want.line_byte) begin
			$error("line_byte: expected %h, actual %h", want.line_byte, got.line_byte);
			faults++;
		end
		if (got.byte_valid !== want.byte_valid) begin
			$error("byte_valid: expected %b, actual %b", want.byte_valid, got.byte_valid);
			faults++;
		end
		if (got.line_done !== want.line_done) begin
			$error("line_done: expected %b, actual %b", want.line_done, got.line_done);
			faults++;
		end
	endfunction
endclass

module delimited_line_selector_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	dls_pkg::in_beat_t  in_data;
	logic               out_valid;
	logic               out_ready;
	dls_pkg::out_beat_t out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [63:0]        cfg_data;

	segment_tracker tracker;
	int give_pct;
	int take_pct;
	int give_now;
	int take_now;
	int unsigned items_sent;

	delimited_line_selector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) tracker.compare_result(out_data);
			out_ready <= ($urandom_range(99) >= take_now);
		end
	end

	task automatic push_beat(input dls_pkg::in_beat_t beat);
		while ($urandom_range(99) < give_now) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.absorb_beat(beat);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		push_beat('{text_byte: b, byte_present: 1'b1, end_of_text: last});
	endtask

	task automatic send_bare(input logic last);
		push_beat('{text_byte: 8'($urandom), byte_present: 1'b0, end_of_text: last});
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.write_reg(idx, val);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (32) @(posedge clk);
	endtask

	task automatic configure(input logic [63:0] brk, input logic [3:0] len,
			input logic [15:0] line);
		logic [63:0] len_word;
		logic [63:0] line_word;
		len_word = {$urandom, $urandom};
		len_word[3:0] = len;
		line_word = {$urandom, $urandom};
		line_word[15:0] = line;
		settle();
		write_cfg(dls_pkg::CFG_BREAK_BYTES, brk);
		write_cfg(dls_pkg::CFG_BREAK_LENGTH, len_word);
		write_cfg(dls_pkg::CFG_LINE_INDEX, line_word);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_config();
		logic [63:0] brk;
		logic [3:0]  len;
		logic [15:0] line;
		int r;
		r = $urandom_range(19);
		if (r == 0) len = 4'd0;
		else if (r == 1) len = 4'($urandom_range(9, 15));
		else if (r == 2) len = 4'd8;
		else len = 4'($urandom_range(1, 4));
		r = $urandom_range(9);
		if (r == 0) brk = '0;
		else if (r == 1) brk = '1;
		else if (r == 2) brk = {$urandom, $urandom};
		else begin
			for (int k = 0; k < 8; k++) brk[8*k +: 8] = 8'($urandom_range(8'h61, 8'h63));
		end
		r = $urandom_range(9);
		if (r == 0) line = 16'hFFFF;
		else if (r == 1) line = 16'($urandom);
		else line = 16'($urandom_range(0, 3));
		configure(brk, len, line);
	endtask

	task automatic random_text();
		logic [7:0] txt[$];
		int n;
		int blen;
		int kind;
		int cut;
		blen = (tracker.brk_len > 8) ? 8 : tracker.brk_len;
		n = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
		while (txt.size() < n) begin
			kind = $urandom_range(9);
			if (kind < 3 && blen > 0) begin
				for (int j = 0; j < blen; j++) txt.push_back(tracker.brk_str[8*j +: 8]);
			end else if (kind < 5 && blen > 1) begin
				cut = $urandom_range(1, blen - 1);
				for (int j = 0; j < cut; j++) txt.push_back(tracker.brk_str[8*j +: 8]);
				if ($urandom_range(1)) txt.push_back(8'($urandom));
			end else if (kind < 8) begin
				cut = $urandom_range(0, (blen > 0) ? blen - 1 : 0);
				txt.push_back(tracker.brk_str[8*cut +: 8]);
			end else begin
				txt.push_back(8'($urandom));
			end
		end
		if (txt.size() == 0) begin
			send_bare(1'b1);
		end else begin
			for (int k = 0; k < txt.size(); k++) begin
				if ($urandom_range(9) == 0) send_bare(1'b0);
				if (k == txt.size() - 1) begin
					if ($urandom_range(1)) begin
						send_byte(txt[k], 1'b1);
					end else begin
						send_byte(txt[k], 1'b0);
						send_bare(1'b1);
					end
				end else begin
					send_byte(txt[k], 1'b0);
				end
			end
		end
	endtask

	initial begin
		int unsigned target;
		tracker = new();
		items_sent = 0;
		give_pct = 38;
		take_pct = 78;
		give_now = give_pct;
		take_now = take_pct;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= dls_pkg::CFG_BREAK_BYTES;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h41, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_bare(1'b1);
		send_bare(1'b0);
		send_bare(1'b1);

		configure('1, 4'd2, 16'd1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hFF, 1'b1);

		configure(64'h0807060504030201, 4'd15, 16'd0);
		for (int k = 1; k <= 9; k++) send_byte(8'(k), 1'b0);
		send_byte(8'h01, 1'b1);

		configure({$urandom, $urandom}, 4'd0, 16'd0);
		send_byte(8'h7E, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b1);

		for (int phase = 0; phase < 3; phase++) begin
			give_pct = (phase == 0) ? 38 : (phase == 1) ? 78 : 0;
			take_pct = (phase == 0) ? 78 : (phase == 1) ? 38 : 0;
			give_now = give_pct;
			take_now = take_pct;
			target = items_sent + 92;
			random_config();
			while (items_sent < target) begin
				if ($urandom_range(7) == 0) random_config();
				random_text();
			end
		end

		in_valid <= 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.faults == 0 && tracker.awaited.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
